/* rtl/lba_pkg.sv */
// Package for the lifetime block aliasing unit.
// Holds payload and command types, sizing constants and the saturating adder.
// No dependencies.
`timescale 1ns / 1ps

package lba_pkg;

  // Default sizing, handed to the top level as parameter defaults
  localparam int MAX_BLOCKS_DEF = 64;
  localparam int MAX_PASSES_DEF = 256;

  // Fixed field widths
  localparam int PASS_W  = 8;
  localparam int SIZE_W  = 32;
  localparam int SUM_W   = 48;
  localparam int BIDX_W  = 6;
  localparam int WORD_W  = SIZE_W + PASS_W;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Input item kinds
  localparam logic KIND_PLACE = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [PASS_W-1:0] first_use;
    logic [PASS_W-1:0] last_use;
    logic [SIZE_W-1:0] size_bytes;
    logic              is_transient;
    logic              is_used;
  } lba_in_t;

  typedef struct packed {
    logic [BIDX_W-1:0] block_index;
    logic              assigned;
    logic              reused;
    logic              overflow;
    logic [SUM_W-1:0]  bytes_virtual;
    logic [SUM_W-1:0]  bytes_physical;
  } lba_out_t;

  // Classified command from the front
  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_SKIP,
    OP_PLACE
  } lba_op_t;

  typedef struct packed {
    lba_op_t           op;
    logic [PASS_W-1:0] first;
    logic [PASS_W-1:0] last;
    logic [SIZE_W-1:0] size;
  } lba_cmd_t;

  // Back end scan engine states
  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } lba_state_t;

  // Add a size to a running total, saturating at all ones
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                               input logic [SIZE_W-1:0] add);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + {{(SUM_W + 1 - SIZE_W){1'b0}}, add};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

/* rtl/lifetime_block_aliasing_unit.sv */
// Top level of the lifetime block aliasing unit: front, command queue, back.
// Uses lba_pkg, lba_front, lba_queue, lba_back (with lba_ram).
//
//   port group  | direction | handshake            | word
//   in_         | input     | in_valid / in_ready   | lba_in_t
//   out_        | output    | out_valid / out_ready | lba_out_t
//
// A clear or skipped word, or a placed word on an empty table, is done in
// the back end without a scan; any other placed word is checked against the
// block table RAM, one read per cycle, over at most count entries
// (count = blocks in the table). Front register and queue take words ahead.
// Reset (rst_n low, synchronous) empties the queue and the table count and
// zeroes the totals; table contents need no clearing. A stalled output holds
// the back end only; the front keeps filling the queue.
`timescale 1ns / 1ps

module lifetime_block_aliasing_unit #(
  parameter int MAX_BLOCKS = lba_pkg::MAX_BLOCKS_DEF,
  parameter int MAX_PASSES = lba_pkg::MAX_PASSES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lba_pkg::lba_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lba_pkg::lba_out_t out_data
);
  import lba_pkg::*;

  logic     push_valid, push_ready;
  lba_cmd_t push_data;
  logic     pop_valid, pop_ready;
  lba_cmd_t pop_data;

  // Accept and classify
  lba_front #(
    .MAX_PASSES (MAX_PASSES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Decouple front from back
  lba_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Scan, place and report
  lba_back #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* rtl/lba_ram.sv */
// Generic simple dual port RAM with registered read.
// One write port, one read port. Depends on nothing.
`timescale 1ns / 1ps

module lba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/lba_front.sv */
// Front end: accepts input words, clamps pass positions and classifies them.
// Uses lba_pkg; feeds lba_queue.
`timescale 1ns / 1ps

module lba_front #(
  parameter int MAX_PASSES = lba_pkg::MAX_PASSES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lba_pkg::lba_in_t  in_data,
  output logic              push_valid,
  input  logic              push_ready,
  output lba_pkg::lba_cmd_t push_data
);
  import lba_pkg::*;

  localparam int PASS_MAX = (MAX_PASSES - 1 > (1 << PASS_W) - 1) ?
                            (1 << PASS_W) - 1 : MAX_PASSES - 1;
  localparam logic [PASS_W-1:0] PassMax = PASS_W'(PASS_MAX);

  logic     fr_valid_r, fr_valid_nxt;
  lba_cmd_t fr_cmd_r, fr_cmd_nxt;
  logic     take;

  assign in_ready = !fr_valid_r || push_ready;
  assign take     = in_valid && in_ready;

  // Classify the incoming word
  always_comb begin
    fr_cmd_nxt       = fr_cmd_r;
    fr_valid_nxt     = fr_valid_r && !push_ready;
    if (take) begin
      fr_valid_nxt   = 1'b1;
      fr_cmd_nxt.first = (in_data.first_use > PassMax) ? PassMax : in_data.first_use;
      fr_cmd_nxt.last  = (in_data.last_use > PassMax) ? PassMax : in_data.last_use;
      fr_cmd_nxt.size  = in_data.size_bytes;
      if (in_data.kind == KIND_CLEAR) begin
        fr_cmd_nxt.op = OP_CLEAR;
      end else if (in_data.is_transient && in_data.is_used) begin
        fr_cmd_nxt.op = OP_PLACE;
      end else begin
        fr_cmd_nxt.op = OP_SKIP;
      end
    end
  end

  // Hold the classified command until the queue takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
    fr_cmd_r <= fr_cmd_nxt;
  end

  assign push_valid = fr_valid_r;
  assign push_data  = fr_cmd_r;

endmodule

/* rtl/lba_queue.sv */
// Short command queue between front and back end.
// Uses lba_pkg for the command type and depth.
`timescale 1ns / 1ps

module lba_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  lba_pkg::lba_cmd_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output lba_pkg::lba_cmd_t pop_data
);
  import lba_pkg::*;

  lba_cmd_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push, pop;

  assign push_ready = cnt_r != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slot_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/lba_back.sv */
// Back end: first-fit scan of the block table, append, totals and result word.
// Uses lba_pkg and lba_ram; fed by lba_queue.
`timescale 1ns / 1ps

module lba_back #(
  parameter int MAX_BLOCKS = lba_pkg::MAX_BLOCKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  lba_pkg::lba_cmd_t pop_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lba_pkg::lba_out_t out_data
);
  import lba_pkg::*;

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [CNT_W-1:0] BlkMax = CNT_W'(MAX_BLOCKS);

  lba_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SUM_W-1:0]  sum_v_r, sum_v_nxt;
  logic [SUM_W-1:0]  sum_p_r, sum_p_nxt;
  lba_cmd_t          cmd_r, cmd_nxt;
  logic [CNT_W-1:0]  scan_addr_r, scan_addr_nxt;
  logic              chk_valid_r, chk_valid_nxt;
  logic [CNT_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  lba_out_t          out_r, out_nxt;

  logic              out_free;
  logic              issue;
  logic              fit;
  logic              wr_en, rd_en;
  logic [IDX_W-1:0]  wr_addr, rd_addr;
  logic [WORD_W-1:0] wr_data, rd_data;
  logic [SIZE_W-1:0] rd_size;
  logic [PASS_W-1:0] rd_free;
  logic [IDX_W+BIDX_W-1:0] idx_wide;

  // Block table: size in the upper bits, free-after position in the lower
  lba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_size  = rd_data[WORD_W-1:PASS_W];
  assign rd_free  = rd_data[PASS_W-1:0];
  assign out_free = !out_valid_r || out_ready;
  assign issue    = (state_r == ST_SCAN) && (scan_addr_r < count_r);
  assign fit      = (rd_free < cmd_r.first) && (rd_size >= cmd_r.size);
  assign rd_en    = issue;
  assign rd_addr  = scan_addr_r[IDX_W-1:0];

  // Sequence commands: clear and skip finish at once, place scans the table or appends at once to an empty one
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    sum_v_nxt     = sum_v_r;
    sum_p_nxt     = sum_p_r;
    cmd_nxt       = cmd_r;
    scan_addr_nxt = scan_addr_r;
    chk_valid_nxt = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    pop_ready     = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = count_r[IDX_W-1:0];
    wr_data       = {cmd_r.size, cmd_r.last};
    idx_wide      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (pop_valid && out_free) begin
          pop_ready = 1'b1;
          unique case (pop_data.op)
            OP_CLEAR: begin
              count_nxt     = '0;
              sum_v_nxt     = '0;
              sum_p_nxt     = '0;
              out_valid_nxt = 1'b1;
              out_nxt       = '0;
            end
            OP_SKIP: begin
              out_valid_nxt = 1'b1;
              out_nxt       = '0;
              out_nxt.bytes_virtual  = sum_v_r;
              out_nxt.bytes_physical = sum_p_r;
            end
            OP_PLACE: begin
              sum_v_nxt = sat_add(sum_v_r, pop_data.size);
              cmd_nxt   = pop_data;
              if (count_r == '0) begin
                // Empty table: append block zero right away
                wr_en         = 1'b1;
                wr_addr       = '0;
                wr_data       = {pop_data.size, pop_data.last};
                count_nxt     = CNT_W'(1);
                sum_p_nxt     = sat_add(sum_p_r, pop_data.size);
                out_valid_nxt = 1'b1;
                out_nxt       = '0;
                out_nxt.assigned       = 1'b1;
                out_nxt.bytes_virtual  = sum_v_nxt;
                out_nxt.bytes_physical = sum_p_nxt;
              end else begin
                state_nxt     = ST_SCAN;
                scan_addr_nxt = '0;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_nxt       = '0;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Issue the next read while checking the previous one
        scan_addr_nxt = scan_addr_r + CNT_W'(issue);
        chk_valid_nxt = issue;
        chk_idx_nxt   = scan_addr_r;
        if (chk_valid_r) begin
          if (fit) begin
            // Reuse: keep the size, move free-after to the new last use
            wr_en         = 1'b1;
            wr_addr       = chk_idx_r[IDX_W-1:0];
            wr_data       = {rd_size, cmd_r.last};
            idx_wide      = {{BIDX_W{1'b0}}, chk_idx_r[IDX_W-1:0]};
            chk_valid_nxt = 1'b0;
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
            out_nxt.block_index    = idx_wide[BIDX_W-1:0];
            out_nxt.assigned       = 1'b1;
            out_nxt.reused         = 1'b1;
            out_nxt.bytes_virtual  = sum_v_r;
            out_nxt.bytes_physical = sum_p_r;
          end else if (chk_idx_r == count_r - CNT_W'(1)) begin
            // Nothing fit: append, or flag a full table
            chk_valid_nxt = 1'b0;
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
            out_nxt.bytes_virtual  = sum_v_r;
            out_nxt.bytes_physical = sum_p_r;
            if (count_r < BlkMax) begin
              wr_en     = 1'b1;
              idx_wide  = {{BIDX_W{1'b0}}, count_r[IDX_W-1:0]};
              count_nxt = count_r + CNT_W'(1);
              sum_p_nxt = sat_add(sum_p_r, cmd_r.size);
              out_nxt.block_index    = idx_wide[BIDX_W-1:0];
              out_nxt.assigned       = 1'b1;
              out_nxt.bytes_physical = sum_p_nxt;
            end else begin
              out_nxt.overflow = 1'b1;
            end
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      sum_v_r     <= '0;
      sum_p_r     <= '0;
      chk_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sum_v_r     <= sum_v_nxt;
      sum_p_r     <= sum_p_nxt;
      chk_valid_r <= chk_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r       <= cmd_nxt;
    scan_addr_r <= scan_addr_nxt;
    chk_idx_r   <= chk_idx_nxt;
    out_r       <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
